### design/ffas_pkg.sv
// Shared types, constants and state codes for the first-fit aligned suballocator.
package ffas_pkg;

  localparam int MAX_CHUNKS  = 8;
  localparam int MAX_ENTRIES = 64;

  localparam int CIW = $clog2(MAX_CHUNKS);
  localparam int CCW = $clog2(MAX_CHUNKS + 1);
  localparam int EIW = $clog2(MAX_ENTRIES);
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = CIW + EIW;
  localparam int DEPTH = MAX_CHUNKS * MAX_ENTRIES;
  localparam int WW  = 35;

  localparam logic [31:0] CHUNK_BYTES_RST = 32'd67108864;
  localparam logic [31:0] GRAN_BYTES_RST  = 32'd1024;

  typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  typedef enum logic {CFG_CHUNK_BYTES = 1'b0, CFG_GRAN_BYTES = 1'b1} cfg_idx_t;

  typedef struct packed {
    logic        op;
    logic [31:0] owner_handle;
    logic [31:0] request_bytes;
    logic [31:0] align_bytes;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  chunk_index;
    logic [31:0] block_offset;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] blk_start;
    logic [31:0] blk_end;
    logic [31:0] blk_owner;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RESP,
    S_F_CHUNK, S_F_CHECK, S_F_SHRD, S_F_SHWR,
    S_A_EPAD, S_A_EPADW, S_A_CHUNK, S_A_RD, S_A_RD2, S_A_NX,
    S_A_R1, S_A_R1W, S_A_R2W, S_A_CMP, S_A_INS, S_A_INSC, S_A_WR, S_A_NEW
  } state_t;

endpackage

### design/ffas_rem.sv
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit per cycle.
module ffas_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ffas_pkg::WW-1:0]   num,
  input  logic [31:0]               den,
  output logic                      done,
  output logic [31:0]               rem
);
  import ffas_pkg::*;

  localparam int CW = $clog2(WW + 1);

  logic [WW-1:0] q_r, q_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   trial;

  assign trial = {rem_r, q_r[WW-1]};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = num;
      rem_nxt = 32'd0;
      den_nxt = den;
      cnt_nxt = CW'(WW);
    end else if (cnt_r != '0) begin
      q_nxt   = {q_r[WW-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, den_r}) ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      cnt_nxt = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### design/first_fit_aligned_suballocator.sv
// First-fit aligned suballocator. One request is in work at a time; the next beat is taken
// only once the result of the last one has loaded into the output register.
// Free scans each open chunk's blocks for the owner handle, then moves the later blocks down.
// Allocate: an end padding remainder when the granule exceeds the alignment, then for each gap
// tried a serial remainder for alignment (and a second one for end padding), then block moves.
// Synchronous reset clears chunk counts and free bytes; the 512-entry table RAM is not cleared.
module first_fit_aligned_suballocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffas_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffas_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import ffas_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;
  logic   rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t wdata;

  state_t state_r, state_nxt;
  logic [31:0] chunk_bytes_r, gran_r;
  logic [ECW-1:0] used_r [MAX_CHUNKS];
  logic [ECW-1:0] used_nxt [MAX_CHUNKS];
  logic [31:0] free_r [MAX_CHUNKS];
  logic [31:0] free_nxt [MAX_CHUNKS];
  logic [CCW-1:0] open_r, open_nxt;
  logic [CCW-1:0] c_r, c_nxt;
  logic [ECW-1:0] i_r, i_nxt, pos_r, pos_nxt;
  logic        op_r, op_nxt;
  logic [31:0] handle_r, handle_nxt, size_r, size_nxt, align_r, align_nxt;
  logic [31:0] cur_end_r, cur_end_nxt, next_r, next_nxt;
  logic [WW-1:0] loc_r, loc_nxt, padded_r, padded_nxt, e_r, e_nxt, end_r, end_nxt;
  out_beat_t   res_r, res_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic          div_start, div_done;
  logic [WW-1:0] div_num;
  logic [31:0]   div_den, div_rem;

  logic [CIW-1:0] c_idx;
  logic [ECW-1:0] cur_used;
  logic [ECW:0]   i_p1;
  logic           c_end, more_next, free_ok, e_fits, gran_on, match, fit, ins_shift;
  logic [31:0]    gran_eff, delta, gpad, space, used_bytes;
  logic [WW-1:0]  loc_w, e_w;
  logic [32:0]    back;

  ffas_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign c_idx     = c_r[CIW-1:0];
  assign cur_used  = used_r[c_idx];
  assign i_p1      = {1'b0, i_r} + (ECW+1)'(1);
  assign c_end     = (c_r == open_r);
  assign more_next = (i_p1 < {1'b0, cur_used});
  assign free_ok   = (free_r[c_idx] > size_r);
  assign gran_eff  = (gran_r == 32'd0) ? 32'd1 : gran_r;
  assign gran_on   = (gran_eff > align_r);
  assign e_fits    = (e_r <= WW'(chunk_bytes_r));
  assign match     = (rdata_r.blk_owner == handle_r);
  assign delta     = (div_rem == 32'd0) ? 32'd0 : align_r - div_rem;
  assign gpad      = (div_rem == 32'd0) ? 32'd0 : gran_eff - div_rem;
  assign loc_w     = WW'(cur_end_r) + WW'(delta);
  assign e_w       = WW'(size_r) + WW'(gpad);
  assign space     = (next_r > cur_end_r) ? next_r - cur_end_r : 32'd0;
  assign fit       = (WW'(space) > padded_r);
  assign ins_shift = (rdata_r.blk_start > loc_r[31:0]);
  assign used_bytes = end_r[31:0] - loc_r[31:0];
  assign back      = {1'b0, free_r[c_idx]} + {1'b0, rdata_r.blk_end - rdata_r.blk_start};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_FREE) begin
            state_nxt = (in_data.owner_handle == 32'd0) ? S_RESP : S_F_CHUNK;
          end else begin
            state_nxt = S_A_EPAD;
          end
        end
      end
      S_RESP:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      S_F_CHUNK: begin
        if (c_end) state_nxt = S_RESP;
        else if (i_r < cur_used) state_nxt = S_F_CHECK;
      end
      S_F_CHECK: state_nxt = match ? S_F_SHRD : S_F_CHUNK;
      S_F_SHRD:  state_nxt = more_next ? S_F_SHWR : S_RESP;
      S_F_SHWR:  state_nxt = S_F_SHRD;
      S_A_EPAD:  state_nxt = gran_on ? S_A_EPADW : S_A_CHUNK;
      S_A_EPADW: if (div_done) state_nxt = S_A_CHUNK;
      S_A_CHUNK: begin
        if (c_end) state_nxt = S_A_NEW;
        else if (free_ok && cur_used == '0 && e_fits) state_nxt = S_A_WR;
        else if (free_ok && cur_used != '0 && cur_used < ECW'(MAX_ENTRIES)) state_nxt = S_A_RD;
      end
      S_A_RD:    state_nxt = S_A_RD2;
      S_A_RD2:   state_nxt = more_next ? S_A_NX : S_A_R1;
      S_A_NX:    state_nxt = S_A_R1;
      S_A_R1:    state_nxt = S_A_R1W;
      S_A_R1W:   if (div_done) state_nxt = gran_on ? S_A_R2W : S_A_CMP;
      S_A_R2W:   if (div_done) state_nxt = S_A_CMP;
      S_A_CMP: begin
        if (fit) state_nxt = S_A_INS;
        else state_nxt = more_next ? S_A_RD : S_A_CHUNK;
      end
      S_A_INS:   state_nxt = (pos_r == '0) ? S_A_WR : S_A_INSC;
      S_A_INSC:  state_nxt = ins_shift ? S_A_INS : S_A_WR;
      S_A_WR:    state_nxt = S_RESP;
      S_A_NEW:   state_nxt = (open_r < CCW'(MAX_CHUNKS) && e_fits) ? S_A_WR : S_RESP;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    used_nxt = used_r;
    free_nxt = free_r;
    open_nxt = open_r;
    c_nxt = c_r;
    i_nxt = i_r;
    pos_nxt = pos_r;
    op_nxt = op_r;
    handle_nxt = handle_r;
    size_nxt = size_r;
    align_nxt = align_r;
    cur_end_nxt = cur_end_r;
    next_nxt = next_r;
    loc_nxt = loc_r;
    padded_nxt = padded_r;
    e_nxt = e_r;
    end_nxt = end_r;
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en = 1'b0;
    rd_addr = {c_idx, i_r[EIW-1:0]};
    wr_en = 1'b0;
    wr_addr = {c_idx, i_r[EIW-1:0]};
    wdata = rdata_r;
    div_start = 1'b0;
    div_num = WW'(size_r);
    div_den = gran_eff;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.op;
          handle_nxt = in_data.owner_handle;
          size_nxt = in_data.request_bytes;
          align_nxt = (in_data.align_bytes == 32'd0) ? 32'd1 : in_data.align_bytes;
          c_nxt = '0;
          i_nxt = '0;
          res_nxt = '{status: ST_NULL, chunk_index: 3'd0, block_offset: 32'd0};
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      S_F_CHUNK: begin
        if (c_end) begin
          res_nxt = '{status: ST_NOT_FOUND, chunk_index: 3'd0, block_offset: 32'd0};
        end else if (i_r >= cur_used) begin
          c_nxt = c_r + CCW'(1);
          i_nxt = '0;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_F_CHECK: begin
        if (match) begin
          free_nxt[c_idx] = back[32] ? 32'hFFFF_FFFF : back[31:0];
          res_nxt = '{status: ST_DONE, chunk_index: 3'(c_r),
                      block_offset: rdata_r.blk_start};
        end else begin
          i_nxt = i_r + ECW'(1);
        end
      end
      S_F_SHRD: begin
        if (more_next) begin
          rd_en = 1'b1;
          rd_addr = {c_idx, i_p1[EIW-1:0]};
        end else begin
          used_nxt[c_idx] = cur_used - ECW'(1);
        end
      end
      S_F_SHWR: begin
        wr_en = 1'b1;
        i_nxt = i_r + ECW'(1);
      end
      S_A_EPAD: begin
        c_nxt = '0;
        e_nxt = WW'(size_r);
        div_start = gran_on;
      end
      S_A_EPADW: if (div_done) e_nxt = e_w;
      S_A_CHUNK: begin
        i_nxt = '0;
        pos_nxt = '0;
        loc_nxt = '0;
        end_nxt = e_r;
        if (!c_end) begin
          if (!(free_ok && ((cur_used == '0 && e_fits) ||
                            (cur_used != '0 && cur_used < ECW'(MAX_ENTRIES))))) begin
            c_nxt = c_r + CCW'(1);
          end
        end
      end
      S_A_RD: rd_en = 1'b1;
      S_A_RD2: begin
        cur_end_nxt = rdata_r.blk_end;
        next_nxt = chunk_bytes_r;
        if (more_next) begin
          rd_en = 1'b1;
          rd_addr = {c_idx, i_p1[EIW-1:0]};
        end
      end
      S_A_NX: next_nxt = rdata_r.blk_start;
      S_A_R1: begin
        div_start = 1'b1;
        div_num = WW'(cur_end_r);
        div_den = align_r;
      end
      S_A_R1W: begin
        if (div_done) begin
          loc_nxt = loc_w;
          padded_nxt = WW'(size_r) + WW'(delta);
          div_start = gran_on;
          div_num = loc_w + WW'(size_r);
        end
      end
      S_A_R2W: if (div_done) padded_nxt = padded_r + WW'(gpad);
      S_A_CMP: begin
        pos_nxt = cur_used;
        end_nxt = WW'(cur_end_r) + padded_r;
        if (!fit) begin
          i_nxt = i_r + ECW'(1);
          if (!more_next) c_nxt = c_r + CCW'(1);
        end
      end
      S_A_INS: begin
        if (pos_r != '0) begin
          rd_en = 1'b1;
          rd_addr = {c_idx, EIW'(pos_r - ECW'(1))};
        end
      end
      S_A_INSC: begin
        if (ins_shift) begin
          wr_en = 1'b1;
          wr_addr = {c_idx, pos_r[EIW-1:0]};
          pos_nxt = pos_r - ECW'(1);
        end
      end
      S_A_WR: begin
        wr_en = 1'b1;
        wr_addr = {c_idx, pos_r[EIW-1:0]};
        wdata = '{blk_start: loc_r[31:0], blk_end: end_r[31:0], blk_owner: handle_r};
        used_nxt[c_idx] = cur_used + ECW'(1);
        free_nxt[c_idx] = (free_r[c_idx] > used_bytes) ? free_r[c_idx] - used_bytes : 32'd0;
        res_nxt = '{status: ST_DONE, chunk_index: 3'(c_r), block_offset: loc_r[31:0]};
      end
      S_A_NEW: begin
        if (open_r < CCW'(MAX_CHUNKS) && e_fits) begin
          c_nxt = open_r;
          open_nxt = open_r + CCW'(1);
          used_nxt[open_r[CIW-1:0]] = '0;
          free_nxt[open_r[CIW-1:0]] = chunk_bytes_r;
          pos_nxt = '0;
          loc_nxt = '0;
          end_nxt = e_r;
        end else begin
          res_nxt = '{status: ST_NO_ROOM, chunk_index: 3'd0, block_offset: 32'd0};
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wdata;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      open_r <= '0;
      out_valid_r <= 1'b0;
      chunk_bytes_r <= CHUNK_BYTES_RST;
      gran_r <= GRAN_BYTES_RST;
      for (int k = 0; k < MAX_CHUNKS; k++) begin
        used_r[k] <= '0;
        free_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      open_r <= open_nxt;
      out_valid_r <= out_valid_nxt;
      used_r <= used_nxt;
      free_r <= free_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHUNK_BYTES: chunk_bytes_r <= cfg_wdata;
          CFG_GRAN_BYTES:  gran_r <= cfg_wdata;
          default:         gran_r <= gran_r;
        endcase
      end
    end
    c_r <= c_nxt;
    i_r <= i_nxt;
    pos_r <= pos_nxt;
    op_r <= op_nxt;
    handle_r <= handle_nxt;
    size_r <= size_nxt;
    align_r <= align_nxt;
    cur_end_r <= cur_end_nxt;
    next_r <= next_nxt;
    loc_r <= loc_nxt;
    padded_r <= padded_nxt;
    e_r <= e_nxt;
    end_r <= end_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= CCW'(MAX_CHUNKS))
    else $error("open chunk count exceeds limit");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_A_WR |-> cur_used < ECW'(MAX_ENTRIES))
    else $error("insert into full block table");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != S_IDLE)
    else $error("accepted beat left block idle");

  a_op_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_F_CHECK || state_r == S_F_SHWR) |-> op_r == OP_FREE)
    else $error("free path entered on allocate");
`endif

endmodule

### tb/first_fit_aligned_suballocator_test.sv
// Self-checking testbench for the first-fit aligned suballocator with a cycle-free predictor.
module first_fit_aligned_suballocator_test;
  import ffas_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic in_fired = 1'b0;

  first_fit_aligned_suballocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  in_beat_t  pending_requests[$];
  out_beat_t expected_grants[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  // allocator shadow state
  logic [31:0] blk_lo[MAX_CHUNKS][MAX_ENTRIES];
  logic [31:0] blk_hi[MAX_CHUNKS][MAX_ENTRIES];
  logic [31:0] blk_own[MAX_CHUNKS][MAX_ENTRIES];
  int unsigned blk_count[MAX_CHUNKS];
  logic [31:0] free_bytes[MAX_CHUNKS];
  int unsigned open_chunks = 0;
  logic [31:0] chunk_size = CHUNK_BYTES_RST;
  logic [31:0] granule = GRAN_BYTES_RST;

  initial begin
    for (int c = 0; c < MAX_CHUNKS; c++) begin
      blk_count[c] = 0;
      free_bytes[c] = '0;
    end
  end

  function automatic logic [63:0] tail_pad(logic [63:0] pos, logic [63:0] g, logic [63:0] a);
    logic [63:0] r;
    if (g <= a) return 64'd0;
    r = pos % g;
    return (r != 0) ? g - r : 64'd0;
  endfunction

  function automatic bit fresh_fit(logic [63:0] sz, logic [63:0] a, logic [63:0] g,
                                   output logic [63:0] e);
    e = sz + tail_pad(sz, g, a);
    return e <= {32'd0, chunk_size};
  endfunction

  function automatic bit gap_search(int c, logic [63:0] sz, logic [63:0] a, logic [63:0] g,
                                    output logic [63:0] loc, output logic [63:0] e);
    int unsigned n;
    logic [63:0] prev, pos, padded, r, nxt, space;
    n = blk_count[c];
    loc = 0;
    e = 0;
    if (n == 0) return fresh_fit(sz, a, g, e);
    if (n >= MAX_ENTRIES) return 1'b0;
    for (int i = 0; i < n; i++) begin
      prev = blk_hi[c][i];
      pos = prev;
      padded = sz;
      r = pos % a;
      if (r != 0) begin
        pos += a - r;
        padded += a - r;
      end
      padded += tail_pad(pos + sz, g, a);
      nxt = (i + 1 == n) ? {32'd0, chunk_size} : {32'd0, blk_lo[c][i+1]};
      space = (nxt > prev) ? nxt - prev : 64'd0;
      if (space > padded) begin
        loc = pos;
        e = prev + padded;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void place_block(int c, logic [31:0] own, logic [31:0] loc,
                                      logic [31:0] e);
    int pos;
    logic [31:0] taken;
    pos = blk_count[c];
    taken = e - loc;
    while (pos > 0 && blk_lo[c][pos-1] > loc) begin
      blk_lo[c][pos] = blk_lo[c][pos-1];
      blk_hi[c][pos] = blk_hi[c][pos-1];
      blk_own[c][pos] = blk_own[c][pos-1];
      pos--;
    end
    blk_lo[c][pos] = loc;
    blk_hi[c][pos] = e;
    blk_own[c][pos] = own;
    blk_count[c]++;
    free_bytes[c] = (free_bytes[c] > taken) ? free_bytes[c] - taken : 32'd0;
  endfunction

  function automatic out_beat_t grant_for(in_beat_t b);
    out_beat_t o;
    logic [63:0] sz, a, g, loc, e, back;
    logic [31:0] s;
    int unsigned n;
    o = '0;
    o.status = ST_DONE;
    sz = {32'd0, b.request_bytes};
    a = (b.align_bytes == 0) ? 64'd1 : {32'd0, b.align_bytes};
    g = (granule == 0) ? 64'd1 : {32'd0, granule};
    if (b.op == OP_FREE) begin
      if (b.owner_handle == 0) begin
        o.status = ST_NULL;
        return o;
      end
      for (int c = 0; c < open_chunks; c++) begin
        n = blk_count[c];
        for (int i = 0; i < n; i++) begin
          if (blk_own[c][i] == b.owner_handle) begin
            s = blk_lo[c][i];
            back = {32'd0, free_bytes[c]} + {32'd0, blk_hi[c][i] - s};
            free_bytes[c] = (back > 64'hFFFFFFFF) ? 32'hFFFFFFFF : back[31:0];
            for (int k = i; k + 1 < n; k++) begin
              blk_lo[c][k] = blk_lo[c][k+1];
              blk_hi[c][k] = blk_hi[c][k+1];
              blk_own[c][k] = blk_own[c][k+1];
            end
            blk_count[c] = n - 1;
            o.chunk_index = c[2:0];
            o.block_offset = s;
            return o;
          end
        end
      end
      o.status = ST_NOT_FOUND;
      return o;
    end
    for (int c = 0; c < open_chunks; c++) begin
      if ({32'd0, free_bytes[c]} > sz && gap_search(c, sz, a, g, loc, e)) begin
        place_block(c, b.owner_handle, loc[31:0], e[31:0]);
        o.chunk_index = c[2:0];
        o.block_offset = loc[31:0];
        return o;
      end
    end
    if (open_chunks < MAX_CHUNKS && fresh_fit(sz, a, g, e)) begin
      blk_count[open_chunks] = 0;
      free_bytes[open_chunks] = chunk_size;
      place_block(open_chunks, b.owner_handle, 32'd0, e[31:0]);
      o.chunk_index = open_chunks[2:0];
      open_chunks++;
      return o;
    end
    o.status = ST_NO_ROOM;
    return o;
  endfunction

  function automatic void queue_request(in_beat_t b);
    pending_requests = {pending_requests, b};
  endfunction

  // predict on input accept, check on output accept, track register writes
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && cfg_we) begin
      if (cfg_index == CFG_CHUNK_BYTES) chunk_size <= cfg_wdata;
      else granule <= cfg_wdata;
    end
    if (rst_n && in_valid && !in_stall) expected_grants = {expected_grants, grant_for(in_data)};
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (out_data.status != want.status || out_data.chunk_index != want.chunk_index ||
            out_data.block_offset != want.block_offset) begin
          $display("%0t: mismatch expected st=%0d ch=%0d off=%h actual st=%0d ch=%0d off=%h",
                   $time, want.status, want.chunk_index, want.block_offset,
                   out_data.status, out_data.chunk_index, out_data.block_offset);
          errors++;
        end
      end
    end
  end

  // mark the beat taken at this edge
  always @(posedge clk) begin
    in_fired <= rst_n && in_valid && !in_stall;
  end

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fired)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_request != 0 && hold_left == 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic drain();
    wait (pending_requests.size() == 0 && !in_valid);
    wait (expected_grants.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_beat_t make_req(logic op, logic [31:0] h, logic [31:0] sz,
                                        logic [31:0] a);
    in_beat_t b;
    b.op = op;
    b.owner_handle = h;
    b.request_bytes = sz;
    b.align_bytes = a;
    return b;
  endfunction

  function automatic in_beat_t random_req();
    logic [31:0] h, sz, a, lim;
    int pick;
    pick = $urandom_range(99);
    if (pick < 90) h = $urandom_range(1, 24);
    else if (pick < 95) h = 32'd0;
    else h = $urandom;
    lim = (chunk_size > 64) ? chunk_size / 6 : 32'd4;
    pick = $urandom_range(99);
    if (pick < 92) sz = $urandom_range(1, (lim > 1) ? lim : 1);
    else sz = $urandom;
    if (sz == 0) sz = 1;
    pick = $urandom_range(99);
    if (pick < 50) a = 32'd1 << $urandom_range(0, 12);
    else if (pick < 93) a = $urandom_range(1, 300);
    else a = $urandom | 32'd1;
    return make_req($urandom_range(99) < 52 ? OP_FREE : OP_ALLOC, h, sz, a);
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) queue_request(random_req());
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_request(make_req(OP_ALLOC, 32'd1, 32'd1, 32'd1));
    queue_request(make_req(OP_ALLOC, 32'd2, 32'hFFFFFFFF, 32'd1));
    queue_request(make_req(OP_ALLOC, 32'd3, 32'd100, 32'h80000000));
    queue_request(make_req(OP_ALLOC, 32'd0, 32'd10, 32'd16));
    queue_request(make_req(OP_FREE, 32'd0, 32'd0, 32'd1));
    queue_request(make_req(OP_FREE, 32'hDEADBEEF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    queue_request(make_req(OP_FREE, 32'd1, 32'd5, 32'd1));
    queue_request(make_req(OP_ALLOC, 32'd5, 32'd300, 32'd64));
    queue_request(make_req(OP_ALLOC, 32'd5, 32'd300, 32'd64));
    queue_request(make_req(OP_FREE, 32'd5, 32'd0, 32'd1));
    queue_request(make_req(OP_ALLOC, 32'd6, 32'd7, 32'hFFFFFFFF));
    queue_request(make_req(OP_ALLOC, 32'd7, 32'd67108864, 32'd1));
    queue_request(make_req(OP_ALLOC, 32'hFFFFFFFF, 32'd1025, 32'd2048));
    queue_request(make_req(OP_FREE, 32'hFFFFFFFF, 32'd0, 32'd1));
    queue_request(make_req(OP_FREE, 32'd7, 32'd0, 32'd1));
    drain();

    random_phase(90);

    write_reg(CFG_CHUNK_BYTES, 32'd8192);
    write_reg(CFG_GRAN_BYTES, 32'd1);
    send_idle_pct = 53;
    random_phase(90);

    write_reg(CFG_CHUNK_BYTES, 32'hFFFFFFFF);
    write_reg(CFG_GRAN_BYTES, 32'hFFFFFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    random_phase(90);

    write_reg(CFG_CHUNK_BYTES, 32'd1);
    write_reg(CFG_GRAN_BYTES, 32'd4096);
    random_phase(30);

    // hold off results while requests keep coming
    write_reg(CFG_CHUNK_BYTES, 32'd65536);
    write_reg(CFG_GRAN_BYTES, 32'd64);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    hold_request = 400;
    random_phase(110);

    // fill one block table to its limit, then release it
    write_reg(CFG_GRAN_BYTES, 32'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 70; i++)
      queue_request(make_req(OP_ALLOC, 32'd1000 + i, 32'd1, 32'd1));
    drain();
    for (int i = 0; i < 70; i++)
      queue_request(make_req(OP_FREE, 32'd1000 + i, 32'd0, 32'd1));
    drain();

    if (errors == 0 && expected_grants.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1000000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
